@@ sv/length_prefixed_frame_deframer_unit_assert.svh @@
// Assertion macros shared by the deframer checker.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LPFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define LPFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ sv/lpfd_pkg.sv @@
// Shared types and constants of the length-prefixed frame deframer.
package lpfd_pkg;

  localparam logic [3:0]  HEADER_BYTES = 4'd12;
  localparam logic [16:0] LIMIT_CAP    = 17'd65536;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  typedef struct packed {
    logic        has;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] main_id;
    logic [15:0] sub_id;
    logic [31:0] sequence_res;
    logic [15:0] payload_length;
    logic        last;
  } lpfd_res_t;

endpackage

@@ sv/lpfd_core.sv @@
// Frame state of the deframer and the per-byte decode that produces at most one result.
module lpfd_core
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_read,
  input  logic [16:0] max_frame_length,
  output lpfd_res_t   res
);

  logic [31:0] length_r, length_nxt;
  logic [15:0] main_r, main_nxt;
  logic [15:0] sub_r, sub_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [3:0]  hcount_r, hcount_nxt;
  logic [15:0] left_r, left_nxt;
  logic        discard_r, discard_nxt;

  logic [16:0] limit;
  logic [31:0] len_full;
  logic        len_bad;
  logic [15:0] plen;

  assign limit    = (max_frame_length > LIMIT_CAP) ? LIMIT_CAP : max_frame_length;
  assign len_full = {rx_byte, length_r[23:0]};
  assign len_bad  = (len_full == 32'd0) || (len_full < {28'd0, HEADER_BYTES}) ||
                    (len_full >= {15'd0, limit});
  assign plen     = 16'(length_r - {28'd0, HEADER_BYTES});

  always_comb begin
    length_nxt  = length_r;
    main_nxt    = main_r;
    sub_nxt     = sub_r;
    seq_nxt     = seq_r;
    hcount_nxt  = hcount_r;
    left_nxt    = left_r;
    discard_nxt = discard_r;
    res         = '0;
    if (step) begin
      if (discard_r) begin
        if (end_of_read) begin
          discard_nxt = 1'b0;
        end
      end else if (hcount_r < HEADER_BYTES) begin
        case (hcount_r)
          4'd0:    length_nxt[7:0]   = rx_byte;
          4'd1:    length_nxt[15:8]  = rx_byte;
          4'd2:    length_nxt[23:16] = rx_byte;
          4'd3:    length_nxt[31:24] = rx_byte;
          4'd4:    main_nxt[7:0]     = rx_byte;
          4'd5:    main_nxt[15:8]    = rx_byte;
          4'd6:    sub_nxt[7:0]      = rx_byte;
          4'd7:    sub_nxt[15:8]     = rx_byte;
          4'd8:    seq_nxt[7:0]      = rx_byte;
          4'd9:    seq_nxt[15:8]     = rx_byte;
          4'd10:   seq_nxt[23:16]    = rx_byte;
          4'd11:   seq_nxt[31:24]    = rx_byte;
          default: ;
        endcase
        hcount_nxt = hcount_r + 4'd1;
        if (hcount_r == 4'd3 && len_bad) begin
          hcount_nxt  = 4'd0;
          left_nxt    = 16'd0;
          discard_nxt = !end_of_read;
          res.has     = 1'b1;
          res.kind    = KIND_ERROR;
          res.last    = 1'b1;
        end
        if (hcount_r == HEADER_BYTES - 4'd1) begin
          left_nxt = plen;
          if (plen == 16'd0) begin
            hcount_nxt         = 4'd0;
            res.has            = 1'b1;
            res.kind           = KIND_EMPTY;
            res.main_id        = main_r;
            res.sub_id         = sub_r;
            res.sequence_res   = seq_nxt;
            res.payload_length = plen;
            res.last           = 1'b1;
          end
        end
      end else if (left_r == 16'd0) begin
        hcount_nxt = 4'd0;
      end else begin
        left_nxt           = left_r - 16'd1;
        res.has            = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.data_byte      = rx_byte;
        res.main_id        = main_r;
        res.sub_id         = sub_r;
        res.sequence_res   = seq_r;
        res.payload_length = plen;
        res.last           = (left_r == 16'd1);
        if (left_r == 16'd1) begin
          hcount_nxt = 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r  <= 32'd0;
      main_r    <= 16'd0;
      sub_r     <= 16'd0;
      seq_r     <= 32'd0;
      hcount_r  <= 4'd0;
      left_r    <= 16'd0;
      discard_r <= 1'b0;
    end else begin
      length_r  <= length_nxt;
      main_r    <= main_nxt;
      sub_r     <= sub_nxt;
      seq_r     <= seq_nxt;
      hcount_r  <= hcount_nxt;
      left_r    <= left_nxt;
      discard_r <= discard_nxt;
    end
  end

endmodule

@@ sv/length_prefixed_frame_deframer_unit.sv @@
// Top level of the length-prefixed frame deframer: byte register, decode, result register.
//
//   Channel  Direction  Handshake              Carries
//   in       input      in_valid / in_ready    rx_byte, end_of_read
//   out      output     out_valid / out_ready  kind, data_byte, header fields, last
//   cfg      input      cfg_valid / cfg_ready  max_frame_length
//
// One byte is taken per cycle unless a held result stalls the pipe; a byte's result
// is registered after the byte register. The rate is set by the single decode step
// between the byte register and the result register. Reset is synchronous and active
// low and sets the limit to 8192. A result that is not taken holds the pipe; the byte
// register takes at most one more byte behind it. The configuration port is always ready.
module length_prefixed_frame_deframer_unit
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_read,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_main_id,
  output logic [15:0] out_sub_id,
  output logic [31:0] out_sequence_res,
  output logic [15:0] out_payload_length,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_max_frame_length
);

  logic        byte_valid_r;
  logic [7:0]  byte_r;
  logic        eor_r;
  logic        advance;
  logic [16:0] limit_r;
  lpfd_res_t   res;
  lpfd_res_t   res_r;
  logic        out_valid_r;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !byte_valid_r || advance;
  assign cfg_ready = 1'b1;

  lpfd_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (byte_valid_r && advance),
    .rx_byte          (byte_r),
    .end_of_read      (eor_r),
    .max_frame_length (limit_r),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
      eor_r  <= in_end_of_read;
    end
    if (advance && res.has) begin
      res_r <= res;
    end
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      limit_r      <= 17'd8192;
    end else begin
      if (in_ready) begin
        byte_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= byte_valid_r && res.has;
      end
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_max_frame_length;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = res_r.kind;
  assign out_data_byte      = res_r.data_byte;
  assign out_main_id        = res_r.main_id;
  assign out_sub_id         = res_r.sub_id;
  assign out_sequence_res   = res_r.sequence_res;
  assign out_payload_length = res_r.payload_length;
  assign out_last           = res_r.last;

endmodule

@@ sv/lpfd_checker.sv @@
// Port-level checker for the deframer and its bind to the top level.
`include "length_prefixed_frame_deframer_unit_assert.svh"

module lpfd_checker
  import lpfd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_data_byte,
  input logic [15:0] out_main_id,
  input logic [15:0] out_sub_id,
  input logic [31:0] out_sequence_res,
  input logic [15:0] out_payload_length,
  input logic        out_last
);

  logic [90:0] out_bundle;
  logic        error_clean;
  logic        empty_clean;

  assign out_bundle  = {out_kind, out_data_byte, out_main_id, out_sub_id, out_sequence_res,
                        out_payload_length, out_last};
  assign error_clean = out_last && out_main_id == 16'd0 && out_sub_id == 16'd0 &&
                       out_sequence_res == 32'd0 && out_payload_length == 16'd0 &&
                       out_data_byte == 8'd0;
  assign empty_clean = out_last && out_payload_length == 16'd0 && out_data_byte == 8'd0;

  `LPFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bundle))
  `LPFD_ASSERT_NOW(a_error_clean, out_valid && out_kind == KIND_ERROR, error_clean)
  `LPFD_ASSERT_NOW(a_empty_frame, out_valid && out_kind == KIND_EMPTY, empty_clean)
  `LPFD_ASSERT_NOW(a_payload_len, out_valid && out_kind == KIND_PAYLOAD, out_payload_length != 16'd0)

endmodule

bind length_prefixed_frame_deframer_unit lpfd_checker u_lpfd_checker (.*);

@@ dv/tb_length_prefixed_frame_deframer_unit.sv @@
// Self-checking testbench for the length-prefixed frame deframer unit.
`timescale 1ns / 1ps

module tb_length_prefixed_frame_deframer_unit;
  import lpfd_pkg::*;

  localparam int unsigned PHASE_ITEMS = 180;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_end_of_read = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [16:0] cfg_max_frame_length = 17'd8192;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_main_id;
  logic [15:0] out_sub_id;
  logic [31:0] out_sequence_res;
  logic [15:0] out_payload_length;
  logic        out_last;
  logic        cfg_ready;

  length_prefixed_frame_deframer_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .in_end_of_read       (in_end_of_read),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_data_byte        (out_data_byte),
    .out_main_id          (out_main_id),
    .out_sub_id           (out_sub_id),
    .out_sequence_res     (out_sequence_res),
    .out_payload_length   (out_payload_length),
    .out_last             (out_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_frame_length (cfg_max_frame_length)
  );

  logic [8:0]  rx_byte_q[$];
  lpfd_res_t   expected_q[$];
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned n_errors = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit          idle_en = 1'b1;

  logic [16:0] limit_reg = 17'd8192;
  logic [31:0] len_word;
  logic [15:0] main_word;
  logic [15:0] sub_word;
  logic [31:0] seq_word;
  logic [3:0]  hdr_cnt;
  logic [15:0] pay_left;
  logic        dropping;

  function automatic logic [31:0] eff_limit();
    return (limit_reg > LIMIT_CAP) ? 32'(LIMIT_CAP) : 32'(limit_reg);
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [7:0] data, logic last_flag);
    lpfd_res_t r;
    r = '0;
    r.has = 1'b1;
    r.kind = kind;
    r.data_byte = data;
    r.last = last_flag;
    if (kind != KIND_ERROR) begin
      r.main_id = main_word;
      r.sub_id = sub_word;
      r.sequence_res = seq_word;
      r.payload_length = 16'(len_word - 32'(HEADER_BYTES));
    end
    expected_q.push_back(r);
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic eor);
    if (dropping) begin
      if (eor) dropping = 1'b0;
      return;
    end
    if (hdr_cnt < HEADER_BYTES) begin
      if (hdr_cnt < 4'd4) len_word[8 * hdr_cnt +: 8] = b;
      else if (hdr_cnt < 4'd6) main_word[8 * (hdr_cnt - 4) +: 8] = b;
      else if (hdr_cnt < 4'd8) sub_word[8 * (hdr_cnt - 6) +: 8] = b;
      else seq_word[8 * (hdr_cnt - 8) +: 8] = b;
      hdr_cnt = hdr_cnt + 4'd1;
      if (hdr_cnt == 4'd4 && (len_word == 32'd0 || len_word >= eff_limit() ||
                              len_word < 32'(HEADER_BYTES))) begin
        hdr_cnt = 4'd0;
        pay_left = 16'd0;
        dropping = !eor;
        push_result(KIND_ERROR, 8'h00, 1'b1);
        return;
      end
      if (hdr_cnt == HEADER_BYTES) begin
        pay_left = 16'(len_word - 32'(HEADER_BYTES));
        if (pay_left == 16'd0) begin
          hdr_cnt = 4'd0;
          push_result(KIND_EMPTY, 8'h00, 1'b1);
        end
      end
    end else if (pay_left == 16'd0) begin
      hdr_cnt = 4'd0;
    end else begin
      pay_left = pay_left - 16'd1;
      push_result(KIND_PAYLOAD, b, pay_left == 16'd0);
      if (pay_left == 16'd0) hdr_cnt = 4'd0;
    end
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin : byte_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
      limit_reg = 17'd8192;
      len_word = '0;
      main_word = '0;
      sub_word = '0;
      seq_word = '0;
      hdr_cnt = '0;
      pay_left = '0;
      dropping = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte, in_end_of_read);
        n_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && idle_en && $urandom_range(0, 11) == 0)
          send_gap = $urandom_range(1, 14);
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (rx_byte_q.size() != 0) begin
          {in_end_of_read, in_rx_byte} <= rx_byte_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    lpfd_res_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("Unexpected result: kind %0d data %02h last %0d", out_kind,
                     out_data_byte, out_last);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.kind !== out_kind || exp_r.data_byte !== out_data_byte ||
              exp_r.main_id !== out_main_id || exp_r.sub_id !== out_sub_id ||
              exp_r.sequence_res !== out_sequence_res ||
              exp_r.payload_length !== out_payload_length || exp_r.last !== out_last) begin
            n_errors++;
            if (n_errors <= 10)
              $display({"Result mismatch: expected kind %0d data %02h main %04h sub %04h ",
                        "seq %08h len %0d last %0d, got kind %0d data %02h main %04h ",
                        "sub %04h seq %08h len %0d last %0d"},
                       exp_r.kind, exp_r.data_byte, exp_r.main_id, exp_r.sub_id,
                       exp_r.sequence_res, exp_r.payload_length, exp_r.last,
                       out_kind, out_data_byte, out_main_id, out_sub_id,
                       out_sequence_res, out_payload_length, out_last);
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [7:0] b, input logic eor);
    rx_byte_q.push_back({eor, b});
    n_queued++;
  endtask

  task automatic send_header(input logic [31:0] len, input logic [15:0] mid,
                             input logic [15:0] sid, input logic [31:0] seqn);
    logic [95:0] hdr;
    hdr = {seqn, sid, mid, len};
    for (int i = 0; i < 12; i++) send(hdr[8 * i +: 8], $urandom_range(0, 7) == 0);
  endtask

  task automatic send_frame(input logic [31:0] len);
    send_header(len, 16'($urandom), 16'($urandom), $urandom);
    repeat (len - 12) send(8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  // A rejected length drops the rest of the chunk, so a chunk end follows unless the
  // length byte itself closed the chunk.
  task automatic send_bad(input logic [31:0] len, input logic eor_last);
    for (int i = 0; i < 3; i++) send(len[8 * i +: 8], $urandom_range(0, 3) == 0);
    send(len[31:24], eor_last);
    if (!eor_last) begin
      repeat ($urandom_range(0, 5)) send(8'($urandom), 1'b0);
      send(8'($urandom), 1'b1);
    end
  endtask

  task automatic wait_taken();
    do @(negedge clk); while (n_taken != n_queued);
  endtask

  task automatic wait_quiet();
    wait_taken();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // After a broken sequence, feed bytes until the deframer is back at a frame boundary.
  task automatic realign();
    while (1) begin
      wait_taken();
      if (dropping) send(8'($urandom), 1'b1);
      else if (hdr_cnt == 4'd0) break;
      else if (hdr_cnt < 4'd4) repeat (4 - hdr_cnt) send(8'hFF, 1'b1);
      else if (hdr_cnt < HEADER_BYTES)
        repeat (12 - hdr_cnt) send(8'($urandom), $urandom_range(0, 1));
      else repeat ((pay_left == 16'd0) ? 1 : pay_left) send(8'($urandom), $urandom_range(0, 1));
    end
  endtask

  task automatic random_frame();
    int unsigned pick;
    logic [31:0] eff;
    logic [31:0] span;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    eff = eff_limit();
    span = (eff > 32'd12) ? eff - 32'd13 : 32'd0;
    if (pick < 60 && eff > 32'd12) begin
      send_frame(32'd12 + $urandom_range(0, (span > 20) ? 20 : span));
    end else if (pick < 70 && eff > 32'd12) begin
      send_frame(32'd12 + $urandom_range(0, (span > 200) ? 200 : span));
    end else if (pick < 75 && eff > 32'd12) begin
      send_frame(32'd12);
    end else if (pick < 90 || eff <= 32'd12) begin
      case ($urandom_range(0, 4))
        0: len = 32'd0;
        1: len = $urandom_range(1, 11);
        2: len = eff + $urandom_range(0, 300);
        3: len = $urandom | 32'h0001_0000;
        default: len = 32'hFFFF_FFFF;
      endcase
      send_bad(len, $urandom_range(0, 3) == 0);
    end else begin
      repeat ($urandom_range(1, 11)) send(8'($urandom), $urandom_range(0, 3) == 0);
      realign();
    end
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned stop;
    stop = n_queued + count;
    while (n_queued < stop) random_frame();
  endtask

  task automatic write_limit(input logic [16:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_frame_length <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_reg = value;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int unsigned waited;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_header(32'd12, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_bad(32'd0, 1'b1);
    send_bad(32'd8192, 1'b0);
    random_phase(PHASE_ITEMS);

    wait_quiet();
    write_limit(17'd13);
    random_phase(PHASE_ITEMS);

    wait_quiet();
    write_limit(17'd65536);
    send_bad(32'd65536, 1'b0);
    random_phase(PHASE_ITEMS);

    wait_quiet();
    write_limit(17'd12);
    random_phase(PHASE_ITEMS / 2);

    wait_quiet();
    write_limit(17'd300);
    random_phase(PHASE_ITEMS);

    wait_quiet();
    write_limit(17'($urandom_range(13, 4096)));
    random_phase(PHASE_ITEMS);

    wait_quiet();
    idle_en = 1'b0;
    write_limit(17'h1FFFF);
    send_bad(32'd65536, 1'b1);
    send_frame(32'd280);
    random_phase(PHASE_ITEMS);

    wait_taken();
    waited = 0;
    while (expected_q.size() != 0 && waited < 10000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    n_errors += expected_q.size();
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
